// ===== src/fit_policy_block_allocator_core_assert.svh =====
// Assertion macros shared by the allocator RTL files.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: whenever ante holds, cons must hold too.
`define FPBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define FPBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPBA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FPBA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/fpba_pkg.sv =====
// Shared types and constants of the fit-policy block allocator.
package fpba_pkg;

  localparam int IDX_FIELD_W = 4;
  localparam int AMT_FIELD_W = 16;
  localparam int POL_W       = 2;
  localparam int NB_W        = 5;
  localparam int TDATA_W     = 24;

  localparam logic [POL_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POL_W-1:0] POL_WORST = 2'd1;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd2;
  localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic CFG_POLICY     = 1'b0;
  localparam logic CFG_NUM_BLOCKS = 1'b1;

  localparam logic [NB_W-1:0] NUM_BLOCKS_RESET = 5'd16;

  // Control inputs of the selection unit.
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [POL_W-1:0] policy;
  } pick_ctl_t;

endpackage

// ===== src/fpba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fpba_pick.sv =====
// Selection unit: keeps the running choice while table entries stream past.
module fpba_pick #(
  parameter int SIZE_W = 16,
  parameter int IDX_W  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fpba_pkg::pick_ctl_t  ctl,
  input  logic [IDX_W-1:0]     idx,
  input  logic [SIZE_W-1:0]    data,
  input  logic [SIZE_W-1:0]    req,
  output logic                 found,
  output logic [IDX_W-1:0]     best_idx,
  output logic [SIZE_W-1:0]    best_val
);

  logic fits;
  logic take;

  // First and next fit keep the first fitting entry in scan order; best and
  // worst fit replace it only on a strictly better size, so ties go early.
  always_comb begin
    fits = (data >= req);
    take = ctl.valid && fits &&
           (!found ||
            (ctl.policy == fpba_pkg::POL_BEST  && data < best_val) ||
            (ctl.policy == fpba_pkg::POL_WORST && data > best_val));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_idx <= idx;
      best_val <= data;
    end
  end

endmodule

// ===== src/fit_policy_block_allocator_core.sv =====
// Top level of the fit-policy block allocator.
//
// The block keeps the remaining size of up to BLOCKS memory blocks in one
// RAM. A load beat (tuser 0) writes one block's size and returns the
// next-fit pointer to block 0; it produces no output beat. An allocate beat
// (tuser 1) reads every block in use, one per cycle through the RAM read
// port, while a selection unit keeps the best candidate under the
// configured policy (best, worst, first or next fit). The chosen block is
// then written back reduced by the request, and one output beat reports the
// grant, the block index and the remainder. The scan is sequential because
// the table RAM has a single read port. Writes happen only in the idle and
// write-back states and reads only in the scan state, so a read never meets
// a write to the same entry. Table entries have no reset value: allocate
// only over blocks that have been loaded. The user must write the
// configuration registers through cfg_we/cfg_index/cfg_data only while no
// allocate is in flight; the block does not enforce this.
module fit_policy_block_allocator_core #(
  parameter int BLOCKS     = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port: index 0 policy, index 1 num_blocks.
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [fpba_pkg::NB_W-1:0]         cfg_data,
  // Request stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, from bit 0: block_index[3:0], amount[19:4], zero fill[23:20].
  input  logic [fpba_pkg::TDATA_W-1:0]      s_tdata,
  // s_tuser: req_type[0].
  input  logic [0:0]                        s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, from bit 0: chosen_block[3:0], remaining_after[19:4], zero[23:20].
  output logic [fpba_pkg::TDATA_W-1:0]      m_tdata,
  // m_tuser: granted[0].
  output logic [0:0]                        m_tuser
);

`include "fit_policy_block_allocator_core_assert.svh"

  localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W = $clog2(BLOCKS + 1);
  localparam int CMP_W = (CNT_W > fpba_pkg::NB_W) ? CNT_W : fpba_pkg::NB_W;
  localparam int IXC_W = (CMP_W > fpba_pkg::IDX_FIELD_W) ? CMP_W : fpba_pkg::IDX_FIELD_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  // Control and configuration registers.
  state_t                       state;
  logic [fpba_pkg::POL_W-1:0]   policy;
  logic [fpba_pkg::NB_W-1:0]    num_blocks;
  logic [IDX_W-1:0]             next_ptr;
  logic                         rd_valid;

  // Scan registers.
  logic [IDX_W-1:0]             scan_pos;
  logic [IDX_W-1:0]             rd_idx;
  logic [CNT_W-1:0]             scan_left;
  logic [SIZE_WIDTH-1:0]        req_amt;

  // Output payload registers.
  logic                         out_granted;
  logic [fpba_pkg::IDX_FIELD_W-1:0] out_chosen;
  logic [fpba_pkg::AMT_FIELD_W-1:0] out_rem;

  // Decoded input beat.
  logic                             in_type;
  logic [fpba_pkg::IDX_FIELD_W-1:0] in_idx;
  logic [SIZE_WIDTH-1:0]            in_amt;
  logic                             in_fire;
  logic                             load_in_range;

  logic [CNT_W-1:0]             cnt;
  logic [CMP_W-1:0]             nb_ext;
  logic [IDX_W-1:0]             start_pos;
  logic [IDX_W-1:0]             pos_next;
  logic [CNT_W-1:0]             pos_inc;
  logic                         out_free;

  // RAM and selection unit connections.
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [SIZE_WIDTH-1:0]        ram_wdata;
  logic [SIZE_WIDTH-1:0]        ram_rdata;
  fpba_pkg::pick_ctl_t          pick_ctl;
  logic                         found;
  logic [IDX_W-1:0]             best_idx;
  logic [SIZE_WIDTH-1:0]        best_val;
  logic [SIZE_WIDTH-1:0]        rest;

  always_comb begin
    in_type  = s_tuser[0];
    in_idx   = s_tdata[fpba_pkg::IDX_FIELD_W-1:0];
    // Requests and sizes are taken at the table's size width.
    in_amt   = SIZE_WIDTH'(s_tdata[fpba_pkg::IDX_FIELD_W +: fpba_pkg::AMT_FIELD_W]);
    s_tready = (state == S_IDLE);
    in_fire  = s_tvalid && s_tready;

    // A load outside the table is dropped but still clears the pointer.
    load_in_range = (IXC_W'(in_idx) < IXC_W'(BLOCKS));

    // A block count above the table size saturates to the table size.
    nb_ext = CMP_W'(num_blocks);
    cnt    = (nb_ext > CMP_W'(BLOCKS)) ? CNT_W'(BLOCKS) : CNT_W'(nb_ext);

    // Next fit starts at the pointer when it lies inside the blocks in use;
    // every other policy, and a stale pointer, starts at block 0.
    start_pos = (policy == fpba_pkg::POL_NEXT && CNT_W'(next_ptr) < cnt) ?
                next_ptr : '0;
    // The scan wraps to block 0 after the last block in use.
    pos_inc  = CNT_W'(scan_pos) + CNT_W'(1);
    pos_next = (pos_inc < cnt) ? IDX_W'(pos_inc) : '0;

    out_free = !m_tvalid || m_tready;
    rest     = best_val - req_amt;

    ram_we    = 1'b0;
    ram_waddr = IDX_W'(in_idx);
    ram_wdata = in_amt;
    if (in_fire && in_type == fpba_pkg::REQ_LOAD && load_in_range) begin
      ram_we = 1'b1;
    end else if (state == S_WB && out_free && found) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = rest;
    end

    pick_ctl.clear  = in_fire && in_type == fpba_pkg::REQ_ALLOC;
    pick_ctl.valid  = rd_valid;
    pick_ctl.policy = policy;

    m_tdata = {{(fpba_pkg::TDATA_W - fpba_pkg::IDX_FIELD_W - fpba_pkg::AMT_FIELD_W){1'b0}},
               out_rem, out_chosen};
    m_tuser = out_granted;
  end

  fpba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_pos),
    .rdata (ram_rdata)
  );

  fpba_pick #(
    .SIZE_W (SIZE_WIDTH),
    .IDX_W  (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pick_ctl),
    .idx      (rd_idx),
    .data     (ram_rdata),
    .req      (req_amt),
    .found    (found),
    .best_idx (best_idx),
    .best_val (best_val)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= fpba_pkg::POL_BEST;
      num_blocks <= fpba_pkg::NUM_BLOCKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::CFG_POLICY:     policy     <= cfg_data[fpba_pkg::POL_W-1:0];
        fpba_pkg::CFG_NUM_BLOCKS: num_blocks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: idle, scan (one read per cycle), wait for the last read data
  // to reach the selection unit, then write back and post the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      next_ptr <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN);
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_type == fpba_pkg::REQ_LOAD) begin
              next_ptr <= '0;
            end else begin
              // With no block in use the request goes straight to a refusal.
              state <= (cnt == '0) ? S_WB : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_left == CNT_W'(1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (found && policy == fpba_pkg::POL_NEXT) begin
              next_ptr <= best_idx;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      req_amt   <= in_amt;
      scan_pos  <= start_pos;
      scan_left <= cnt;
    end else if (state == S_SCAN) begin
      scan_pos  <= pos_next;
      scan_left <= scan_left - CNT_W'(1);
    end
    rd_idx <= scan_pos;
    if (state == S_WB && out_free) begin
      out_granted <= found;
      out_chosen  <= found ? fpba_pkg::IDX_FIELD_W'(best_idx) : '0;
      out_rem     <= found ? fpba_pkg::AMT_FIELD_W'(rest) : '0;
    end
  end

  // The table is never written while a scan reads it.
  `FPBA_ASSERT_IMP(a_no_write_in_scan, clk, rst, ram_we, state != S_SCAN)
  // A scan always has reads left to issue.
  `FPBA_ASSERT_IMP(a_scan_left, clk, rst, state == S_SCAN, scan_left != '0)
  // A granted choice always covers the request, so the remainder never wraps.
  `FPBA_ASSERT_IMP(a_fit_covers, clk, rst, state == S_WB && found, best_val >= req_amt)
  // Read data is marked valid only right after a scan cycle.
  `FPBA_ASSERT_NXT(a_rd_follows_scan, clk, rst, state != S_SCAN, !rd_valid)

endmodule
